@@ hdl/lmcb_pkg.sv @@
// Shared types and codes for the lazy max counter bank.
package lmcb_pkg;

    // Item action codes
    localparam logic [1:0] ACT_INC   = 2'd0;
    localparam logic [1:0] ACT_RAISE = 2'd1;
    localparam logic [1:0] ACT_READ  = 2'd2;

    // Width and reset value of the counters-in-use register
    localparam int          NUM_W     = 11;
    localparam logic [10:0] NUM_RESET = 11'd1024;

    // Controller to datapath commands
    typedef struct packed {
        logic clear_en;   // write zero at the clear pointer and advance it
        logic accept;     // latch item, launch memory read
        logic finish;     // update state, write back, load result
    } t_dp_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic clear_last; // clear pointer is at the last entry
    } t_dp_stat;

endpackage

@@ hdl/lazy_max_counter_bank.sv @@
// Top level of the lazy max counter bank.
//
//  channel   direction  handshake                 payload
//  in        input      i_in_valid / o_in_stall   i_action, i_index
//  out       output     o_out_valid / i_out_stall o_value, o_current_max, o_index_error
//  cfg       input      i_cfg_we                  i_cfg_data
//
// Each item is read from the counter memory through a registered read, then
// lifted, incremented and written back on the single memory port.
// After reset a clear pass writes zero to every entry, with
// o_in_stall high; config writes are taken during it.
// An item may be accepted while the previous result waits; it then holds in
// the update cycle until the result register is free.
module lazy_max_counter_bank
    import lmcb_pkg::*;
#(
    parameter int COUNTERS    = 1024,
    parameter int COUNT_WIDTH = 32
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [NUM_W-1:0] i_cfg_data,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  logic [1:0]       i_action,
    input  logic [9:0]       i_index,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output logic [31:0]      o_value,
    output logic [31:0]      o_current_max,
    output logic             o_index_error
);

    t_dp_cmd  cmd;
    t_dp_stat stat;

    lmcb_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (cmd),
        .i_stat      (stat)
    );

    lmcb_dp #(
        .COUNTERS    (COUNTERS),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_data    (i_cfg_data),
        .i_action      (i_action),
        .i_index       (i_index),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .o_value       (o_value),
        .o_current_max (o_current_max),
        .o_index_error (o_index_error)
    );

endmodule

@@ hdl/lmcb_dp.sv @@
// Datapath: counter memory, floor, running max, config and result registers.
module lmcb_dp
    import lmcb_pkg::*;
#(
    parameter int COUNTERS    = 1024,
    parameter int COUNT_WIDTH = 32
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [NUM_W-1:0] i_cfg_data,
    input  logic [1:0]       i_action,
    input  logic [9:0]       i_index,
    input  t_dp_cmd          i_cmd,
    output t_dp_stat         o_stat,
    output logic [31:0]      o_value,
    output logic [31:0]      o_current_max,
    output logic             o_index_error
);

    localparam int AW = $clog2((COUNTERS > 1) ? COUNTERS : 2);
    localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};

    logic [COUNT_WIDTH-1:0] r_mem [COUNTERS];

    logic [NUM_W-1:0]       r_num;
    logic [AW-1:0]          r_clr_addr;
    logic [AW-1:0]          r_addr;
    logic [1:0]             r_act;
    logic                   r_in_range;
    logic [COUNT_WIDTH-1:0] r_rdata;
    logic [COUNT_WIDTH-1:0] r_floor;
    logic [COUNT_WIDTH-1:0] r_max;
    logic [COUNT_WIDTH-1:0] r_val;
    logic                   r_err;

    logic [COUNT_WIDTH-1:0] n_floor;
    logic [COUNT_WIDTH-1:0] n_max;
    logic [COUNT_WIDTH-1:0] n_val;
    logic                   n_err;
    logic                   n_we;

    logic                   in_range;
    logic [COUNT_WIDTH-1:0] eff;
    logic [COUNT_WIDTH-1:0] inc;
    logic [63:0]            val_ext;
    logic [63:0]            max_ext;

    // Index is live only below both the configured count and the bank size
    assign in_range = (17'(i_index) < 17'(r_num)) && (17'(i_index) < 17'(COUNTERS));

    // Lazy lift to the floor, then saturating increment
    assign eff = (r_rdata < r_floor) ? r_floor : r_rdata;
    assign inc = (eff == CNT_MAX) ? CNT_MAX : eff + 1'b1;

    // Result and state update for the item in flight
    always_comb begin
        n_floor = r_floor;
        n_max   = r_max;
        n_val   = '0;
        n_err   = 1'b0;
        n_we    = 1'b0;
        case (r_act)
            ACT_INC: begin
                if (r_in_range) begin
                    n_we  = 1'b1;
                    n_val = inc;
                    if (inc > r_max) begin
                        n_max = inc;
                    end
                end else begin
                    n_floor = r_max;
                    n_val   = r_max;
                    n_err   = 1'b1;
                end
            end
            ACT_RAISE: begin
                n_floor = r_max;
                n_val   = r_max;
            end
            ACT_READ: begin
                if (r_in_range) begin
                    n_val = eff;
                end
            end
            default: begin
                n_val = '0;
            end
        endcase
    end

    // Counter memory: clear pass, write-back, registered read
    always_ff @(posedge i_clk) begin
        if (i_cmd.clear_en) begin
            r_mem[r_clr_addr] <= '0;
        end else if (i_cmd.finish && n_we) begin
            r_mem[r_addr] <= inc;
        end
        if (i_cmd.accept) begin
            r_rdata <= r_mem[AW'(i_index)];
        end
    end

    // Control and state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num      <= NUM_RESET;
            r_clr_addr <= '0;
            r_floor    <= '0;
            r_max      <= '0;
        end else begin
            if (i_cfg_we) begin
                r_num <= i_cfg_data;
            end
            if (i_cmd.clear_en) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
            if (i_cmd.finish) begin
                r_floor <= n_floor;
                r_max   <= n_max;
            end
        end
    end

    // Item and result payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_act      <= i_action;
            r_addr     <= AW'(i_index);
            r_in_range <= in_range;
        end
        if (i_cmd.finish) begin
            r_val <= n_val;
            r_err <= n_err;
        end
    end

    assign o_stat.clear_last = (r_clr_addr == AW'(COUNTERS - 1));

    assign val_ext       = 64'(r_val);
    assign max_ext       = 64'(r_max);
    assign o_value       = val_ext[31:0];
    assign o_current_max = max_ext[31:0];
    assign o_index_error = r_err;

endmodule

@@ hdl/lmcb_ctrl.sv @@
// Controller: clear pass after reset, item sequencing, result valid.
module lmcb_ctrl
    import lmcb_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_stall,
    output logic     o_out_valid,
    input  logic     i_out_stall,
    output t_dp_cmd  o_cmd,
    input  t_dp_stat i_stat
);

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC
    } t_state;

    t_state r_state;
    logic   r_out_valid;
    logic   out_free;

    // Result register can take a new item this cycle
    assign out_free = !r_out_valid || !i_out_stall;

    assign o_in_stall     = (r_state != ST_IDLE);
    assign o_cmd.clear_en = (r_state == ST_CLEAR);
    assign o_cmd.accept   = (r_state == ST_IDLE) && i_in_valid;
    assign o_cmd.finish   = (r_state == ST_EXEC) && out_free;
    assign o_out_valid    = r_out_valid;

    // State and result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            case (r_state)
                ST_CLEAR: begin
                    if (i_stat.clear_last) begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (i_in_valid) begin
                        r_state <= ST_EXEC;
                    end
                end
                ST_EXEC: begin
                    if (out_free) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
            if (o_cmd.finish) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

@@ tb/lazy_max_counter_bank_test.sv @@
// Self-checking testbench for the lazy max counter bank: directed, random and backpressure tests.
module lazy_max_counter_bank_test
    import lmcb_pkg::*;
();

    localparam int         BANK_SIZE   = 1024;
    localparam int         HOLD_CYCLES = 300;
    localparam int         REPORT_MAX  = 10;
    // Action code the block ignores; it still returns one item
    localparam logic [1:0] ACT_UNUSED  = 2'd3;

    typedef struct packed {
        logic [31:0] value;
        logic [31:0] current_max;
        logic        index_error;
    } t_count_result;

    // DUT ports
    logic             i_clk         = 1'b0;
    logic             i_rst_n       = 1'b0;
    logic             i_cfg_we      = 1'b0;
    logic [NUM_W-1:0] i_cfg_data    = '0;
    logic             i_in_valid    = 1'b0;
    logic             o_in_stall;
    logic [1:0]       i_action      = ACT_INC;
    logic [9:0]       i_index       = '0;
    logic             o_out_valid;
    logic             i_out_stall   = 1'b0;
    logic [31:0]      o_value;
    logic [31:0]      o_current_max;
    logic             o_index_error;

    // Shadow copy of the bank state
    logic [31:0]      count_model [BANK_SIZE];
    logic [31:0]      floor_model;
    logic [31:0]      max_model;
    logic [NUM_W-1:0] limit_model;

    t_count_result    expected_q [$];
    int               fail_count    = 0;
    int               send_idle_pct = 0;
    int               stall_pct     = 0;
    logic             hold_req      = 1'b0;
    int               hold_left     = 0;

    lazy_max_counter_bank dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_action      (i_action),
        .i_index       (i_index),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_value       (o_value),
        .o_current_max (o_current_max),
        .o_index_error (o_index_error)
    );

    always #2 i_clk = ~i_clk;

    // Number of counters actually in use
    function automatic int active_counters();
        return (int'(limit_model) > BANK_SIZE) ? BANK_SIZE : int'(limit_model);
    endfunction

    // Update the shadow state for one item and return the item the block should produce.
    // Saturation at the full count width cannot be reached in a run of this length.
    function automatic t_count_result predict_count(input logic [1:0] act, input logic [9:0] idx);
        t_count_result r;
        logic [31:0]   c;
        r = '0;
        case (act)
            ACT_INC: begin
                if (int'(idx) >= active_counters()) begin
                    // out of range increment acts as raise all
                    floor_model   = max_model;
                    r.value       = floor_model;
                    r.index_error = 1'b1;
                end else begin
                    c = (count_model[idx] < floor_model) ? floor_model : count_model[idx];
                    if (c != '1) begin
                        c = c + 32'd1;
                    end
                    count_model[idx] = c;
                    if (c > max_model) begin
                        max_model = c;
                    end
                    r.value = c;
                end
            end
            ACT_RAISE: begin
                floor_model = max_model;
                r.value     = floor_model;
            end
            ACT_READ: begin
                if (int'(idx) < active_counters()) begin
                    r.value = (count_model[idx] < floor_model) ? floor_model : count_model[idx];
                end
            end
            default: begin
            end
        endcase
        r.current_max = max_model;
        return r;
    endfunction

    // Offer one item, with random idle cycles first, and record its expectation on acceptance
    task automatic send_item(input logic [1:0] act, input logic [9:0] idx);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_action   <= act;
        i_index    <= idx;
        do @(posedge i_clk); while (o_in_stall);
        expected_q.push_back(predict_count(act, idx));
    endtask

    // Mostly well-formed traffic on live counters, plus out-of-range and unused codes
    task automatic send_random_item();
        int          pick;
        int          live;
        logic [9:0]  idx;
        pick = $urandom_range(99);
        live = active_counters();
        idx  = (live > 0) ? 10'($urandom_range(live - 1)) : 10'($urandom_range(1023));
        if (pick < 50) begin
            send_item(ACT_INC, idx);
        end else if (pick < 58) begin
            send_item(ACT_INC, 10'($urandom_range(1023)));
        end else if (pick < 70) begin
            send_item(ACT_RAISE, 10'($urandom_range(1023)));
        end else if (pick < 88) begin
            send_item(ACT_READ, idx);
        end else if (pick < 95) begin
            send_item(ACT_READ, 10'($urandom_range(1023)));
        end else begin
            send_item(ACT_UNUSED, 10'($urandom_range(1023)));
        end
    endtask

    // Drop valid and wait until every expected item has come back
    task automatic drain_results();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (expected_q.size() != 0);
    endtask

    // Change the counters-in-use register with the block idle
    task automatic write_count_limit(input logic [NUM_W-1:0] n);
        drain_results();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= n;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        limit_model = n;
    endtask

    task automatic report_mismatch(input string what, input t_count_result exp_r,
                                   input t_count_result got_r);
        fail_count++;
        if (fail_count <= REPORT_MAX) begin
            $display("mismatch (%s): expected value %h max %h err %b, got value %h max %h err %b",
                     what, exp_r.value, exp_r.current_max, exp_r.index_error,
                     got_r.value, got_r.current_max, got_r.index_error);
        end
    endtask

    // Output side: check accepted items, then pick the next stall
    always @(posedge i_clk) begin : out_check
        t_count_result got_r;
        t_count_result exp_r;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got_r = '{o_value, o_current_max, o_index_error};
            if (expected_q.size() == 0) begin
                report_mismatch("unexpected item", '0, got_r);
            end else begin
                exp_r = expected_q.pop_front();
                if (got_r.value !== exp_r.value || got_r.current_max !== exp_r.current_max ||
                    got_r.index_error !== exp_r.index_error) begin
                    report_mismatch("field", exp_r, got_r);
                end
            end
        end
        i_out_stall <= (hold_left > 0) || ($urandom_range(99) < stall_pct);
    end

    // Long receiver hold-off, counted down here
    always @(posedge i_clk) begin
        if (hold_req) begin
            hold_left <= HOLD_CYCLES;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // Every action code, lift from the floor, reads of untouched entries, unused code
    task automatic test_basic_ops();
        send_idle_pct = 0;
        stall_pct     = 0;
        write_count_limit(NUM_RESET);
        send_item(ACT_INC, 10'd0);
        send_item(ACT_INC, 10'd0);
        send_item(ACT_INC, 10'd1023);
        send_item(ACT_READ, 10'd1023);
        send_item(ACT_READ, 10'd5);
        send_item(ACT_RAISE, 10'd0);
        send_item(ACT_INC, 10'd5);
        send_item(ACT_READ, 10'd6);
        send_item(ACT_INC, 10'd0);
        send_item(ACT_UNUSED, 10'd1023);
        send_item(ACT_READ, 10'd0);
        drain_results();
    endtask

    // One counter, no counters, and a register value above the bank size
    task automatic test_range_limits();
        write_count_limit(11'd1);
        send_item(ACT_INC, 10'd0);
        send_item(ACT_INC, 10'd1);
        send_item(ACT_READ, 10'd1);
        send_item(ACT_READ, 10'd0);
        write_count_limit(11'd0);
        send_item(ACT_INC, 10'd0);
        send_item(ACT_READ, 10'd0);
        send_item(ACT_RAISE, 10'd1023);
        write_count_limit(11'd2047);
        send_item(ACT_INC, 10'd1023);
        send_item(ACT_READ, 10'd1023);
        send_item(ACT_READ, 10'd512);
        drain_results();
    endtask

    task automatic test_random_traffic(input int n_items, input int idle_pct, input int hold_pct,
                                       input logic [NUM_W-1:0] limit);
        write_count_limit(limit);
        send_idle_pct = idle_pct;
        stall_pct     = hold_pct;
        repeat (n_items) send_random_item();
        drain_results();
    endtask

    // Receiver holds off for a long stretch while the sender keeps offering
    task automatic test_backpressure();
        write_count_limit(11'd4);
        send_idle_pct = 0;
        stall_pct     = 0;
        hold_req <= 1'b1;
        @(posedge i_clk);
        hold_req <= 1'b0;
        repeat (40) send_random_item();
        drain_results();
    endtask

    initial begin
        foreach (count_model[k]) count_model[k] = '0;
        floor_model = '0;
        max_model   = '0;
        limit_model = NUM_RESET;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_basic_ops();
        test_range_limits();
        test_random_traffic(250, 0, 0, 11'd8);
        test_random_traffic(250, 62, 0, 11'($urandom_range(1, 40)));
        test_random_traffic(200, 0, 62, 11'd1024);
        test_random_traffic(250, 34, 34, 11'd2047);
        test_random_traffic(100, 34, 34, 11'($urandom_range(0, 2047)));
        test_backpressure();

        // let any trailing activity settle
        drain_results();
        repeat (20) @(posedge i_clk);
        if (fail_count == 0 && expected_q.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #2000000;
        $display("tb: failure");
        $finish;
    end

endmodule
